// ===== sv/rvs_pkg.sv =====
// Shared constants for the Snell refraction vector block.
`default_nettype none
package rvs_pkg;
   localparam int DATA_W = 16;
   localparam int IDX_W = 16;
   localparam int IDX_FRAC = 12;
   localparam int FRAC_BITS_DEF = 14;
   localparam logic [IDX_W-1:0] INDEX_RESET = 16'd6144;
   localparam logic [DATA_W-1:0] OUT_POS_MAX = 16'h7fff;
   localparam logic [DATA_W-1:0] OUT_NEG_MAX = 16'h8000;
endpackage
`default_nettype wire

// ===== sv/rvs_if.sv =====
// Valid/ready channel interfaces for the ray items, result items and index writes.
`default_nettype none
interface rvs_req_if;
   logic valid;
   logic ready;
   logic signed [rvs_pkg::DATA_W-1:0] incident_x;
   logic signed [rvs_pkg::DATA_W-1:0] incident_y;
   logic signed [rvs_pkg::DATA_W-1:0] incident_z;
   logic signed [rvs_pkg::DATA_W-1:0] surface_nx;
   logic signed [rvs_pkg::DATA_W-1:0] surface_ny;
   logic signed [rvs_pkg::DATA_W-1:0] surface_nz;
   modport source (output valid, incident_x, incident_y, incident_z,
                   surface_nx, surface_ny, surface_nz, input ready);
   modport sink (input valid, incident_x, incident_y, incident_z,
                 surface_nx, surface_ny, surface_nz, output ready);
endinterface

interface rvs_rsp_if;
   logic valid;
   logic ready;
   logic signed [rvs_pkg::DATA_W-1:0] refracted_x;
   logic signed [rvs_pkg::DATA_W-1:0] refracted_y;
   logic signed [rvs_pkg::DATA_W-1:0] refracted_z;
   logic total_reflection;
   modport source (output valid, refracted_x, refracted_y, refracted_z,
                   total_reflection, input ready);
   modport sink (input valid, refracted_x, refracted_y, refracted_z,
                 total_reflection, output ready);
endinterface

interface rvs_csr_if;
   logic valid;
   logic ready;
   logic [rvs_pkg::IDX_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/rvs_eta_div.sv =====
// Iterative restoring divider that forms the entering ratio 2^(F+12) / index.
`default_nettype none
module rvs_eta_div #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [rvs_pkg::IDX_W-1:0] divisor,
   output logic busy,
   output logic [FRAC_BITS+12:0] quotient
);
   import rvs_pkg::*;
   localparam int QW = FRAC_BITS + 13;
   localparam int CNT_W = $clog2(QW + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [IDX_W:0] rem_sh;
   logic fits;

   // The dividend is a single one at its top bit, so only the first step shifts in a one.
   assign rem_sh = {rem_ff, (cnt_ff == CNT_W'(QW))};
   assign fits = rem_sh >= {1'b0, divisor};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         cnt_in = CNT_W'(QW);
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? IDX_W'(rem_sh - {1'b0, divisor}) : rem_sh[IDX_W-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(QW);
         rem_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
      end
      quo_ff <= quo_in;
   end

   assign busy = cnt_ff != '0;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== sv/rvs_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
`default_nettype none
module rvs_sqrt #(
   parameter int N = 15,
   parameter int SW = 8
) (
   input  wire logic clock,
   input  wire logic en,
   input  wire logic [2*N-1:0] rad_in,
   input  wire logic [SW-1:0] side_in,
   output logic [N-1:0] root_out,
   output logic [SW-1:0] side_out
);
   localparam int RW = N + 3;

   logic [RW-1:0] rem_ff [N-1];
   logic [2*N-1:0] rad_ff [N-1];
   logic [N-1:0] root_ff [N];
   logic [SW-1:0] side_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_step
      logic [RW-1:0] rem_p, rem_s, trial;
      logic [N-1:0] root_p;
      logic [2*N-1:0] rad_p;
      logic [SW-1:0] side_p;
      logic take;

      if (j == 0) begin : g_first
         assign rem_p = '0;
         assign root_p = '0;
         assign rad_p = rad_in;
         assign side_p = side_in;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign root_p = root_ff[j-1];
         assign rad_p = rad_ff[j-1];
         assign side_p = side_ff[j-1];
      end

      assign rem_s = {rem_p[RW-3:0], rad_p[2*N-1 -: 2]};
      assign trial = RW'({root_p, 2'b01});
      assign take = rem_s >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= {root_p[N-2:0], take};
            side_ff[j] <= side_p;
         end
      end

      if (j < N - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= take ? rem_s - trial : rem_s;
               rad_ff[j] <= rad_p << 2;
            end
         end
      end
   end

   assign root_out = root_ff[N-1];
   assign side_out = side_ff[N-1];
endmodule
`default_nettype wire

// ===== sv/refraction_vector_snell.sv =====
// Top level of the Snell refraction vector pipeline.
// Refracts a unit ray direction at a unit surface normal, both signed Q1.14, using the
// refractive index register (unsigned Q4.12, 0 taken as the smallest index). One item is
// accepted per clock while nothing stalls it; the depth is set by the square root, which
// resolves one bit per stage. A skid register behind the last stage catches the item
// that leaves the last stage as the sink stalls, so the input ready comes from registers
// only; while the skid register holds an item the whole pipeline and the input stall.
// After reset and after every index write the entering ratio 1/index is formed by an
// iterative divider, and no item is accepted while it runs.
`default_nettype none
module refraction_vector_snell #(
   parameter int FRAC_BITS = rvs_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   rvs_req_if.sink req_port,
   rvs_rsp_if.source rsp_port,
   rvs_csr_if.sink csr_port
);
   import rvs_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int DW = (2 * F + 3 > 34) ? 2 * F + 3 : 34;
   localparam int CW = F + 1;
   localparam int EW = F + 13;
   localparam int E2W = F + 25;
   localparam int N = F + 1;
   localparam int KW = EW + 2;
   localparam int TW = F + 32;
   localparam int PW = 2 * DATA_W;
   localparam int SW = 2 * EW + 2 + 6 * DATA_W;
   localparam int NS = N + 8;
   localparam logic [CW-1:0] ONE = {1'b1, {F{1'b0}}};
   localparam logic [DW-1:0] ONE2 = DW'(1) << (2 * F);

   function automatic logic [DATA_W-1:0] to_out(input logic signed [TW-1:0] t);
      logic neg;
      logic [TW-1:0] mag, qv;
      logic [DATA_W-1:0] r;
      neg = t[TW-1];
      mag = neg ? TW'(-t) : TW'(t);
      qv = mag >> F;
      if (neg) r = (qv > TW'(OUT_NEG_MAX)) ? OUT_NEG_MAX : DATA_W'(-qv);
      else r = (qv > TW'(OUT_POS_MAX)) ? OUT_POS_MAX : qv[DATA_W-1:0];
      return r;
   endfunction

   // Index register and ratio divider.
   logic [IDX_W-1:0] index_ff;
   logic [IDX_W-1:0] index_eff;
   logic csr_wr, busy;
   logic [EW-1:0] eta_enter, eta_leave;
   logic [IDX_W+F-1:0] index_sh;

   assign csr_port.ready = 1'b1;
   assign csr_wr = csr_port.valid;
   always_ff @(posedge clock) begin
      if (reset) index_ff <= INDEX_RESET;
      else if (csr_wr) index_ff <= csr_port.data;
   end
   assign index_eff = (index_ff == '0) ? IDX_W'(1) : index_ff;
   assign index_sh = {index_eff, {F{1'b0}}};
   assign eta_leave = EW'(index_sh >> IDX_FRAC);

   rvs_eta_div #(.FRAC_BITS(F)) u_div (
      .clock(clock), .reset(reset), .start(csr_wr), .divisor(index_eff),
      .busy(busy), .quotient(eta_enter)
   );

   // Flow control: every stage advances unless the skid register is holding a result.
   logic [NS-1:0] v_ff;
   logic sk_v_ff, adv, req_take;
   assign adv = !sk_v_ff;
   assign req_port.ready = adv && !busy;
   assign req_take = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], req_take};
   end

   // Stage 0: component products of the dot product.
   logic signed [DATA_W-1:0] iv0_ff [3], nv0_ff [3];
   logic signed [PW-1:0] p0_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         iv0_ff[0] <= req_port.incident_x;
         iv0_ff[1] <= req_port.incident_y;
         iv0_ff[2] <= req_port.incident_z;
         nv0_ff[0] <= req_port.surface_nx;
         nv0_ff[1] <= req_port.surface_ny;
         nv0_ff[2] <= req_port.surface_nz;
         p0_ff[0] <= PW'(req_port.incident_x) * PW'(req_port.surface_nx);
         p0_ff[1] <= PW'(req_port.incident_y) * PW'(req_port.surface_ny);
         p0_ff[2] <= PW'(req_port.incident_z) * PW'(req_port.surface_nz);
      end
   end

   // Stage 1: clamp the cosine, pick the direction and the ratio.
   logic signed [DW-1:0] dot, dot_cl;
   logic [DW-1:0] mag;
   logic enter1;
   assign dot = DW'(p0_ff[0]) + DW'(p0_ff[1]) + DW'(p0_ff[2]);
   always_comb begin
      dot_cl = dot;
      if (dot > $signed(ONE2)) dot_cl = $signed(ONE2);
      else if (dot < -$signed(ONE2)) dot_cl = -$signed(ONE2);
   end
   assign enter1 = dot_cl[DW-1];
   assign mag = enter1 ? DW'(-dot_cl) : DW'(dot_cl);

   logic signed [DATA_W-1:0] iv1_ff [3], nv1_ff [3];
   logic [CW-1:0] c1_ff;
   logic [EW-1:0] eta1_ff;
   logic enter1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         iv1_ff <= iv0_ff;
         nv1_ff <= nv0_ff;
         c1_ff <= CW'(mag >> F);
         eta1_ff <= enter1 ? eta_enter : eta_leave;
         enter1_ff <= enter1;
      end
   end

   // Stage 2: squares of the cosine and ratio, and ratio times cosine.
   logic [2*CW-1:0] cc;
   logic [2*EW-1:0] ee;
   logic [EW+CW-1:0] em;
   assign cc = (2*CW)'(c1_ff) * (2*CW)'(c1_ff);
   assign ee = (2*EW)'(eta1_ff) * (2*EW)'(eta1_ff);
   assign em = (EW+CW)'(eta1_ff) * (EW+CW)'(c1_ff);

   logic signed [DATA_W-1:0] iv2_ff [3], nv2_ff [3];
   logic [CW-1:0] s2_ff;
   logic [E2W-1:0] e2_ff;
   logic [EW-1:0] m2_ff, eta2_ff;
   logic enter2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         iv2_ff <= iv1_ff;
         nv2_ff <= nv1_ff;
         s2_ff <= ONE - CW'(cc >> F);
         e2_ff <= E2W'(ee >> F);
         m2_ff <= EW'(em >> F);
         eta2_ff <= eta1_ff;
         enter2_ff <= enter1_ff;
      end
   end

   // Stage 3: eta^2 (1 - cos^2).
   logic [E2W+CW-1:0] qp;
   assign qp = (E2W+CW)'(e2_ff) * (E2W+CW)'(s2_ff);

   logic signed [DATA_W-1:0] iv3_ff [3], nv3_ff [3];
   logic [E2W-1:0] q3_ff;
   logic [EW-1:0] m3_ff, eta3_ff;
   logic enter3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         iv3_ff <= iv2_ff;
         nv3_ff <= nv2_ff;
         q3_ff <= E2W'(qp >> F);
         m3_ff <= m2_ff;
         eta3_ff <= eta2_ff;
         enter3_ff <= enter2_ff;
      end
   end

   // Stage 4: total reflection test and the radicand for the root.
   logic tir4;
   logic [CW-1:0] k4;
   assign tir4 = q3_ff > E2W'(ONE);
   assign k4 = tir4 ? '0 : CW'(E2W'(ONE) - q3_ff);

   logic [2*N-1:0] rad4_ff;
   logic [SW-1:0] side4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rad4_ff <= {1'b0, k4, {F{1'b0}}};
         side4_ff <= {eta3_ff, m3_ff, enter3_ff, tir4,
                      iv3_ff[0], iv3_ff[1], iv3_ff[2], nv3_ff[0], nv3_ff[1], nv3_ff[2]};
      end
   end

   logic [N-1:0] root;
   logic [SW-1:0] side_sq;
   rvs_sqrt #(.N(N), .SW(SW)) u_sqrt (
      .clock(clock), .en(adv), .rad_in(rad4_ff), .side_in(side4_ff),
      .root_out(root), .side_out(side_sq)
   );

   // Post stage A: the normal coefficient.
   logic [EW-1:0] eta_q, m_q;
   logic enter_q, tir_q;
   logic signed [DATA_W-1:0] iv_q [3], nv_q [3];
   logic signed [KW-1:0] diff;
   assign {eta_q, m_q, enter_q, tir_q, iv_q[0], iv_q[1], iv_q[2],
           nv_q[0], nv_q[1], nv_q[2]} = side_sq;
   assign diff = $signed({2'b00, m_q}) - $signed(KW'(root));

   logic signed [KW-1:0] coef_a_ff;
   logic [EW-1:0] eta_a_ff;
   logic tir_a_ff;
   logic signed [DATA_W-1:0] iv_a_ff [3], nv_a_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         coef_a_ff <= enter_q ? diff : -diff;
         eta_a_ff <= eta_q;
         tir_a_ff <= tir_q;
         iv_a_ff <= iv_q;
         nv_a_ff <= nv_q;
      end
   end

   // Post stage B: the six products.
   logic signed [TW-1:0] eta_x, coef_x;
   assign eta_x = TW'($signed({1'b0, eta_a_ff}));
   assign coef_x = TW'(coef_a_ff);

   logic signed [TW-1:0] pi_ff [3], pn_ff [3];
   logic tir_b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            pi_ff[j] <= eta_x * TW'(iv_a_ff[j]);
            pn_ff[j] <= coef_x * TW'(nv_a_ff[j]);
         end
         tir_b_ff <= tir_a_ff;
      end
   end

   // Post stage C: sum, scale and saturate into the last stage.
   logic [DATA_W-1:0] out_ff [3];
   logic tir_c_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            out_ff[j] <= tir_b_ff ? '0 : to_out(pi_ff[j] + pn_ff[j]);
         end
         tir_c_ff <= tir_b_ff;
      end
   end

   // Skid register catches the last stage's item when the sink stalls.
   logic [DATA_W-1:0] sk_ff [3];
   logic sk_tir_ff;
   always_ff @(posedge clock) begin
      if (reset) sk_v_ff <= 1'b0;
      else if (sk_v_ff) sk_v_ff <= !rsp_port.ready;
      else sk_v_ff <= v_ff[NS-1] && !rsp_port.ready;
   end
   always_ff @(posedge clock) begin
      if (!sk_v_ff) begin
         sk_ff <= out_ff;
         sk_tir_ff <= tir_c_ff;
      end
   end

   assign rsp_port.valid = sk_v_ff || v_ff[NS-1];
   assign rsp_port.refracted_x = sk_v_ff ? sk_ff[0] : out_ff[0];
   assign rsp_port.refracted_y = sk_v_ff ? sk_ff[1] : out_ff[1];
   assign rsp_port.refracted_z = sk_v_ff ? sk_ff[2] : out_ff[2];
   assign rsp_port.total_reflection = sk_v_ff ? sk_tir_ff : tir_c_ff;
endmodule
`default_nettype wire

// ===== test/refraction_vector_snell_tb.sv =====
// Self-checking testbench for the Snell refraction vector pipeline.
`timescale 1ns / 100ps
`default_nettype none
module refraction_vector_snell_tb;
   import rvs_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD = 200;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_RAYS = 650;

   typedef logic signed [DATA_W-1:0] comp_type;

   typedef struct packed {
      comp_type refr_x;
      comp_type refr_y;
      comp_type refr_z;
      logic  tir;
   } refraction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   error_count = 0;
   logic [IDX_W-1:0] index_model = INDEX_RESET;
   bit   hold_request = 1'b0;
   refraction_type expected_rays[$];

   rvs_req_if req_port();
   rvs_rsp_if rsp_port();
   rvs_csr_if csr_port();

   refraction_vector_snell dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_port),
      .rsp_port(rsp_port),
      .csr_port(csr_port)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("refraction_vector_snell test failed");
         $finish;
      end
   end

   // Unsigned product shifted right, capped at 2^62.
   function automatic longint unsigned capped_product(input longint unsigned a,
                                                      input longint unsigned b, input int sh);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> sh;
      if (p > (128'd1 << 62)) return 64'd1 << 62;
      return p[63:0];
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic comp_type saturate_comp(input longint t);
      longint unsigned mag, q;
      mag = (t < 0) ? longint'(-t) : longint'(t);
      q = mag >> FRAC;
      if (t < 0) return (q > 32768) ? comp_type'(OUT_NEG_MAX) : comp_type'(-longint'(q));
      return (q > 32767) ? comp_type'(OUT_POS_MAX) : comp_type'(q);
   endfunction

   function automatic refraction_type predict_ray(input comp_type ix, iy, iz, nx, ny, nz,
                                                  input logic [IDX_W-1:0] index_reg);
      longint one, dot, coef;
      longint unsigned mag, c, r, eta, s, e2, q, k, root, m;
      longint iv[3], nv[3];
      bit entering;
      refraction_type res;
      one = longint'(1) << FRAC;
      iv[0] = ix; iv[1] = iy; iv[2] = iz;
      nv[0] = nx; nv[1] = ny; nv[2] = nz;
      dot = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
      if (dot > one * one) dot = one * one;
      if (dot < -(one * one)) dot = -(one * one);
      entering = dot < 0;
      mag = entering ? -dot : dot;
      c = mag >> FRAC;
      r = (index_reg == 0) ? 1 : index_reg;
      if (entering) eta = (64'd1 << (FRAC + IDX_FRAC)) / r;
      else eta = (r << FRAC) >> IDX_FRAC;
      s = one - ((c * c) >> FRAC);
      e2 = capped_product(eta, eta, FRAC);
      q = capped_product(e2, s, FRAC);
      res = '0;
      if (q > one) begin
         res.tir = 1'b1;
         return res;
      end
      k = one - q;
      root = floor_sqrt(k << FRAC);
      m = capped_product(eta, c, FRAC);
      coef = longint'(m) - longint'(root);
      if (!entering) coef = -coef;
      res.refr_x = saturate_comp(longint'(eta) * iv[0] + coef * nv[0]);
      res.refr_y = saturate_comp(longint'(eta) * iv[1] + coef * nv[1]);
      res.refr_z = saturate_comp(longint'(eta) * iv[2] + coef * nv[2]);
      return res;
   endfunction

   task automatic send_ray(input comp_type ix, iy, iz, nx, ny, nz);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_port.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_port.valid <= 1'b1;
      req_port.incident_x <= ix;
      req_port.incident_y <= iy;
      req_port.incident_z <= iz;
      req_port.surface_nx <= nx;
      req_port.surface_ny <= ny;
      req_port.surface_nz <= nz;
      do @(posedge clock); while (!req_port.ready);
      expected_rays.push_back(predict_ray(ix, iy, iz, nx, ny, nz, index_model));
   endtask

   // Random unit vector in Q1.14.
   task automatic unit_vector(output comp_type vx, vy, vz);
      real x, y, z, len;
      do begin
         x = real'($urandom_range(0, 65535)) - 32768.0;
         y = real'($urandom_range(0, 65535)) - 32768.0;
         z = real'($urandom_range(0, 65535)) - 32768.0;
         len = $sqrt(x * x + y * y + z * z);
      end while (len < 100.0);
      vx = comp_type'($rtoi(x / len * 16384.0));
      vy = comp_type'($rtoi(y / len * 16384.0));
      vz = comp_type'($rtoi(z / len * 16384.0));
   endtask

   task automatic send_random_ray();
      comp_type ix, iy, iz, nx, ny, nz;
      if ($urandom_range(0, 9) < 7) begin
         unit_vector(ix, iy, iz);
         unit_vector(nx, ny, nz);
      end else begin
         ix = comp_type'($urandom); iy = comp_type'($urandom); iz = comp_type'($urandom);
         nx = comp_type'($urandom); ny = comp_type'($urandom); nz = comp_type'($urandom);
      end
      send_ray(ix, iy, iz, nx, ny, nz);
   endtask

   task automatic drain();
      req_port.valid <= 1'b0;
      while (expected_rays.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_index(input logic [IDX_W-1:0] value);
      drain();
      csr_port.valid <= 1'b1;
      csr_port.data <= value;
      do @(posedge clock); while (!csr_port.ready);
      csr_port.valid <= 1'b0;
      index_model = value;
   endtask

   task automatic test_directed();
      send_ray(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_ray(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
      send_ray(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
      send_ray('0, '0, '0, '0, '0, '0);
      // Head-on entering and leaving rays along each axis.
      send_ray(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384);
      send_ray(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384);
      send_ray(-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
      send_ray(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
      // Oblique leaving rays; at index 1.5 all of them are totally reflected.
      send_ray(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384);
      send_ray(16'sd16000, 16'sd0, 16'sd3530, 16'sd0, 16'sd0, 16'sd16384);
      send_ray(16'sd16384, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd16384);
      // Grazing entering ray and one exactly perpendicular to the normal.
      send_ray(16'sd16384, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd16384);
      send_ray(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
      // Oversized vectors push the dot product past the clamp.
      send_ray(16'sd30000, 16'sd30000, 16'sd0, 16'sd30000, 16'sd30000, 16'sd0);
      send_ray(16'sd30000, 16'sd30000, 16'sd0, -16'sd30000, -16'sd30000, 16'sd0);
      drain();
   endtask

   task automatic test_index_settings();
      logic [IDX_W-1:0] settings[7];
      settings = '{16'd0, 16'd1, 16'd65535, 16'd4096, 16'd3000, 16'd9000, INDEX_RESET};
      foreach (settings[i]) begin
         write_index(settings[i]);
         send_ray(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384);
         send_ray(16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384);
         repeat (6) send_random_ray();
      end
   endtask

   task automatic test_random();
      for (int n = 0; n < RANDOM_RAYS; n++) begin
         if (n % 200 == 199) write_index(IDX_W'($urandom_range(1, 65535)));
         send_random_ray();
      end
      write_index(INDEX_RESET);
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (80) send_random_ray();
      drain();
   endtask

   // Result receiver with random stalls and one long hold on request.
   initial begin
      int gap;
      rsp_port.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_port.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_port.valid && rsp_port.ready));
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_port.ready <= 1'b0;
            for (int c = 0; c < LONG_HOLD; c++) @(posedge clock);
            rsp_port.ready <= 1'b1;
         end else begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
               rsp_port.ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_port.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      refraction_type want;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         if (expected_rays.size() == 0) begin
            $error("unexpected result item");
            error_count++;
         end else begin
            want = expected_rays.pop_front();
            if (rsp_port.refracted_x !== want.refr_x) begin
               $error("refracted_x: expected %0d, got %0d", want.refr_x, rsp_port.refracted_x);
               error_count++;
            end
            if (rsp_port.refracted_y !== want.refr_y) begin
               $error("refracted_y: expected %0d, got %0d", want.refr_y, rsp_port.refracted_y);
               error_count++;
            end
            if (rsp_port.refracted_z !== want.refr_z) begin
               $error("refracted_z: expected %0d, got %0d", want.refr_z, rsp_port.refracted_z);
               error_count++;
            end
            if (rsp_port.total_reflection !== want.tir) begin
               $error("total_reflection: expected %0d, got %0d", want.tir,
                      rsp_port.total_reflection);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_port.valid = 1'b0;
      req_port.incident_x = '0;
      req_port.incident_y = '0;
      req_port.incident_z = '0;
      req_port.surface_nx = '0;
      req_port.surface_ny = '0;
      req_port.surface_nz = '0;
      csr_port.valid = 1'b0;
      csr_port.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_index_settings();
      test_backpressure();
      test_random();
      drain();
      if (expected_rays.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("refraction_vector_snell test passed");
      end else begin
         $display("refraction_vector_snell test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
